>>> design/lzhw_pkg.sv
package lzhw_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int MAX_TAIL     = 64;

    // Field widths of one input transaction
    localparam int BYTE_W     = 8;
    localparam int DIST_W     = 13;
    localparam int CLEN_W     = 8;
    localparam int TLEN_W     = 7;
    localparam int TOFS_W     = 12;
    localparam int INDEX_W    = 16;
    localparam int ACTION_W   = 2;
    localparam int CNT_W      = 8;

    // Field positions inside s_axis_tdata
    localparam int BYTE_LSB   = 0;
    localparam int DIST_LSB   = BYTE_LSB + BYTE_W;
    localparam int CLEN_LSB   = DIST_LSB + DIST_W;
    localparam int TLEN_LSB   = CLEN_LSB + CLEN_W;
    localparam int TOFS_LSB   = TLEN_LSB + TLEN_W;
    localparam int INDEX_LSB  = TOFS_LSB + TOFS_W;
    localparam int IN_DATA_W  = INDEX_LSB + INDEX_W;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_COPY  = 2'd1,
        ACT_TAIL  = 2'd2,
        ACT_INDEX = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_TAIL_RD,
        ST_TAIL_XFER
    } state_t;

    // Request from the sequencer to the window memory
    typedef struct packed {
        logic              wr_en;
        addr_t             wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        addr_t             rd_addr;
    } mem_req_t;

    // Request from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic last;
    } out_req_t;

endpackage

>>> design/lzhw_mem.sv
module lzhw_mem
    import lzhw_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [WINDOW_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/lzhw_seq.sv
module lzhw_seq
    import lzhw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [DIST_W-1:0]   distance,
    input  logic [CLEN_W-1:0]   copy_length,
    input  logic [TLEN_W-1:0]   tail_length,
    input  logic [TOFS_W-1:0]   tail_offset,
    input  logic [INDEX_W-1:0]  index,
    input  logic [BYTE_W-1:0]   rd_data,
    input  logic                out_free,
    output mem_req_t            mem_req,
    output out_req_t            out_req
);

    localparam addr_t ADDR_LAST = '1;

    state_t             state_reg, state_next;
    addr_t              wp_reg, wp_next;
    addr_t              src_reg, src_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               accept;
    logic [TLEN_W-1:0]  tail_sat;
    addr_t              sub_a;
    addr_t              sub_b;
    addr_t              start_addr;
    logic               inc_src;
    addr_t              inc_in;
    addr_t              inc_out;
    logic               cnt_last;

    assign accept   = in_valid && in_ready;
    assign cnt_last = (cnt_reg == CNT_W'(1));

    // Clamp the tail length to the longest run
    assign tail_sat = (tail_length > TLEN_W'(MAX_TAIL)) ? TLEN_W'(MAX_TAIL) : tail_length;

    // Start address unit: write pointer minus distance, or minus tail span
    always_comb
    begin
        if (action_t'(action) == ACT_COPY)
        begin
            sub_a = ADDR_W'(distance);
            sub_b = '0;
        end
        else
        begin
            sub_a = ADDR_W'(tail_sat);
            sub_b = ADDR_W'(tail_offset);
        end
    end

    assign start_addr = wp_reg - sub_a - sub_b;

    // Shared incrementer, steps either the source or the write pointer
    assign inc_in  = inc_src ? src_reg : wp_reg;
    assign inc_out = inc_in + ADDR_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (wp_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(action))
                        ACT_COPY:
                        begin
                            if (copy_length != '0)
                            begin
                                state_next = ST_COPY_RD;
                            end
                        end
                        ACT_TAIL:
                        begin
                            if (tail_sat != '0)
                            begin
                                state_next = ST_TAIL_RD;
                            end
                        end
                        ACT_INDEX: state_next = ST_TAIL_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: state_next = cnt_last ? ST_IDLE : ST_COPY_RD;
            ST_TAIL_RD: state_next = ST_TAIL_XFER;
            ST_TAIL_XFER:
            begin
                if (out_free)
                begin
                    state_next = cnt_last ? ST_IDLE : ST_TAIL_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, memory strobes, output load, incrementer select
    always_comb
    begin
        in_ready        = 1'b0;
        inc_src         = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = wp_reg;
        mem_req.wr_data = rd_data;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = src_reg;
        out_req.load    = 1'b0;
        out_req.last    = cnt_last;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = '0;
            end
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                mem_req.wr_data = byte_value;
                mem_req.wr_en   = in_valid && (action_t'(action) == ACT_WRITE);
            end
            ST_COPY_RD:
            begin
                mem_req.rd_en = 1'b1;
                inc_src       = 1'b1;
            end
            ST_COPY_WR:
            begin
                mem_req.wr_en = 1'b1;
            end
            ST_TAIL_RD:
            begin
                mem_req.rd_en = 1'b1;
                inc_src       = 1'b1;
            end
            ST_TAIL_XFER:
            begin
                out_req.load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        wp_next  = wp_reg;
        src_next = src_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wp_next = inc_out;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(action))
                        ACT_WRITE:
                        begin
                            wp_next = inc_out;
                        end
                        ACT_COPY:
                        begin
                            src_next = start_addr;
                            cnt_next = copy_length;
                        end
                        ACT_TAIL:
                        begin
                            src_next = start_addr;
                            cnt_next = CNT_W'(tail_sat);
                        end
                        ACT_INDEX:
                        begin
                            src_next = ADDR_W'(index);
                            cnt_next = CNT_W'(1);
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_COPY_RD:
            begin
                src_next = inc_out;
            end
            ST_COPY_WR:
            begin
                wp_next  = inc_out;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_TAIL_RD:
            begin
                src_next = inc_out;
            end
            ST_TAIL_XFER:
            begin
                if (out_free)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control state; write pointer doubles as the clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
        end
    end

    // Source address and byte count
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        cnt_reg <= cnt_next;
    end

endmodule

>>> design/lz_history_window_unit.sv
// LZ history window. Holds a circular window of WINDOW_DEPTH bytes (4096) and a write
// pointer, both cleared by reset. Each input transaction carries one action in tuser:
// write appends byte_value; copy replays copy_length bytes from distance behind the write
// pointer (overlap allowed, no output); tail emits up to 64 bytes ending tail_offset bytes
// before the write pointer, oldest first, tlast on the final one; index emits the single
// byte at index modulo the window size with tlast set. One memory port pair and one shared
// address incrementer serve every action, one memory access per cycle, and tready stays low
// while an action is in progress. A write completes in the idle state; a copy alternates
// read and write states per byte; tail and index alternate read and transfer states per
// byte and stall while the output register is full and m_axis_tready is low. After reset
// the block zeroes every window location before raising s_axis_tready. An output register
// holds the last result so the next transaction can be taken while it waits.
module lz_history_window_unit
    import lzhw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: byte_value[7:0], distance[20:8], copy_length[28:21], tail_length[35:29],
    //        tail_offset[47:36], index[63:48]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [ACTION_W-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: data_byte[7:0]
    output logic [BYTE_W-1:0]    m_axis_tdata,
    output logic                 m_axis_tlast
);

    mem_req_t          mem_req;
    out_req_t          out_req;
    logic [BYTE_W-1:0] rd_data;
    logic              out_free;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    lzhw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tuser),
        .byte_value  (s_axis_tdata[BYTE_LSB +: BYTE_W]),
        .distance    (s_axis_tdata[DIST_LSB +: DIST_W]),
        .copy_length (s_axis_tdata[CLEN_LSB +: CLEN_W]),
        .tail_length (s_axis_tdata[TLEN_LSB +: TLEN_W]),
        .tail_offset (s_axis_tdata[TOFS_LSB +: TOFS_W]),
        .index       (s_axis_tdata[INDEX_LSB +: INDEX_W]),
        .rd_data     (rd_data),
        .out_free    (out_free),
        .mem_req     (mem_req),
        .out_req     (out_req)
    );

    lzhw_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Output register: load on request, drop when taken
    always_comb
    begin
        if (out_req.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_req.load)
        begin
            out_data_reg <= rd_data;
            out_last_reg <= out_req.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> design/lzhw_checker.sv
module lzhw_checker
    import lzhw_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [IN_DATA_W-1:0] s_axis_tdata,
    input logic [ACTION_W-1:0]  s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [BYTE_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tlast
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its data and flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // A literal write finishes in the cycle it is taken
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser == ACT_WRITE) |=> s_axis_tready)
        else $error("not ready after literal write");

    // A nonempty copy keeps the block busy
    a_copy_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser == ACT_COPY) &&
        (s_axis_tdata[CLEN_LSB +: CLEN_W] != '0) |=> !s_axis_tready)
        else $error("ready during copy");

    // An index read keeps the block busy until its byte is loaded
    a_index_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser == ACT_INDEX) |=> !s_axis_tready)
        else $error("ready during index read");

endmodule

bind lz_history_window_unit lzhw_checker u_lzhw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lzhw_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int RANDOM_ITEMS    = 250;
    localparam int BURST_ITEMS     = 12;

    // One byte leaving the window on the master side
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } out_item_t;

    // Shadow copy of the window; predicts every byte a transaction reads out
    class history_model;
        logic [BYTE_W-1:0] window_mem [WINDOW_DEPTH];
        addr_t             wr_ptr;
        out_item_t         expected_bytes [$];
        int                errors;
        int                matched;

        function new();
            foreach (window_mem[i]) window_mem[i] = '0;
            wr_ptr  = '0;
            errors  = 0;
            matched = 0;
        endfunction

        // Apply one accepted input transaction and queue the bytes it emits
        function void apply_transaction(action_t act, logic [IN_DATA_W-1:0] word);
            logic [BYTE_W-1:0] lit;
            int                back_dist;
            int                clen;
            int                tlen;
            int                tofs;
            addr_t             src;
            out_item_t         item;
            lit       = word[BYTE_LSB +: BYTE_W];
            back_dist = int'(word[DIST_LSB +: DIST_W]);
            clen      = int'(word[CLEN_LSB +: CLEN_W]);
            tlen      = int'(word[TLEN_LSB +: TLEN_W]);
            tofs      = int'(word[TOFS_LSB +: TOFS_W]);
            case (act)
                ACT_WRITE:
                begin
                    window_mem[wr_ptr] = lit;
                    wr_ptr = wr_ptr + 1'b1;
                end
                ACT_COPY:
                begin
                    // Byte-by-byte so overlapping copies repeat fresh bytes
                    src = addr_t'(int'(wr_ptr) - back_dist);
                    for (int n = 0; n < clen; n++)
                    begin
                        window_mem[wr_ptr] = window_mem[src];
                        wr_ptr = wr_ptr + 1'b1;
                        src    = src + 1'b1;
                    end
                end
                ACT_TAIL:
                begin
                    if (tlen > MAX_TAIL)
                        tlen = MAX_TAIL;
                    src = addr_t'(int'(wr_ptr) - tlen - tofs);
                    for (int n = 0; n < tlen; n++)
                    begin
                        item.data_byte = window_mem[src];
                        item.last      = (n == tlen - 1);
                        expected_bytes.push_back(item);
                        src = src + 1'b1;
                    end
                end
                default:
                begin
                    item.data_byte = window_mem[addr_t'(word[INDEX_LSB +: INDEX_W])];
                    item.last      = 1'b1;
                    expected_bytes.push_back(item);
                end
            endcase
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_byte(logic [BYTE_W-1:0] data_byte, logic last);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction: data_byte %02h last %0b",
                       data_byte, last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data_byte !== want.data_byte)
            begin
                $error("data_byte mismatch: expected %02h, actual %02h",
                       want.data_byte, data_byte);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            matched++;
        endfunction

        function void check_drained();
            if (expected_bytes.size() != 0)
            begin
                $error("%0d predicted bytes never arrived", expected_bytes.size());
                errors++;
            end
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic [ACTION_W-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    history_model window_shadow = new();

    bit hold_off_req = 1'b0;
    bit rx_steady    = 1'b0;
    bit tx_steady    = 1'b0;
    int sent_count   = 0;
    int cycle_count  = 0;
    int rx_left      = 0;
    bit rx_ready_now = 1'b0;

    lz_history_window_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return $urandom_range(2);
        else if (r < 9)
            return $urandom_range(8, 3);
        return $urandom_range(40, 15);
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_fields(
        logic [BYTE_W-1:0]  lit,
        logic [DIST_W-1:0]  back_dist,
        logic [CLEN_W-1:0]  clen,
        logic [TLEN_W-1:0]  tlen,
        logic [TOFS_W-1:0]  tofs,
        logic [INDEX_W-1:0] idx
    );
        return {idx, tofs, tlen, clen, back_dist, lit};
    endfunction

    function automatic int tx_gap();
        return tx_steady ? 0 : pick_gap();
    endfunction

    // Offer one transaction, hold it until accepted, then leave valid low for the requested gap
    task automatic send_item(action_t act, logic [IN_DATA_W-1:0] word, int gap);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        window_shadow.apply_transaction(act, word);
        sent_count++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= random_word();
            s_axis_tuser  <= ACTION_W'($urandom_range(3));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Receiver: random ready/stall phases, or one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            rx_ready_now = 1'b0;
            rx_left      = HOLD_OFF_CYCLES;
        end
        else if (rx_left == 0)
        begin
            if (rx_steady)
            begin
                rx_ready_now = 1'b1;
                rx_left      = 1;
            end
            else if ($urandom_range(1) == 0)
            begin
                rx_ready_now = 1'b0;
                rx_left      = pick_gap() + 1;
            end
            else
            begin
                rx_ready_now = 1'b1;
                rx_left      = $urandom_range(8, 1);
            end
        end
        m_axis_tready <= rx_ready_now;
        rx_left--;
    end

    // Check every output transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            window_shadow.check_byte(m_axis_tdata, m_axis_tlast);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [IN_DATA_W-1:0] word;
        action_t              act;
        int                   pick;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero window, wrap-around reads, overlap and degenerate copies
        send_item(ACT_INDEX, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_INDEX, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'hFFFF), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd64, 12'd0, 16'd0), tx_gap());
        send_item(ACT_WRITE, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_WRITE, pack_fields(8'hFF, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_WRITE, pack_fields(8'hA5, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_WRITE, pack_fields(8'h5A, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd4, 12'd0, 16'd0), tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'd1, 8'd10, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'd0, 8'd5, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'd3, 8'd0, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'd4096, 8'd3, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd24, 12'd0, 16'd0), tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'h1FFF, 8'd255, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd127, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd65, 12'd100, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd1, 12'hFFF, 16'd0), tx_gap());
        send_item(ACT_INDEX, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'd2), tx_gap());
        send_item(ACT_INDEX, pack_fields(8'h00, 13'd0, 8'd0, 7'd0, 12'd0, 16'h1003), tx_gap());
        // Write with every ignored field at its maximum
        send_item(ACT_WRITE, pack_fields(8'h01, 13'h1FFF, 8'hFF, 7'h7F, 12'hFFF, 16'hFFFF),
                  tx_gap());
        send_item(ACT_COPY, pack_fields(8'h00, 13'd4, 8'd8, 7'd0, 12'd0, 16'd0), tx_gap());
        send_item(ACT_TAIL, pack_fields(8'h00, 13'd0, 8'd0, 7'd64, 12'hFFF, 16'd0), tx_gap());

        // Random: first a stretch with no idling, then random gaps on both sides
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 50)
            begin
                tx_steady = 1'b0;
                rx_steady = 1'b0;
            end

            // Stall the receiver while a burst of full tails fills the block
            if (k == 90)
            begin
                hold_off_req = 1'b1;
                for (int b = 0; b < BURST_ITEMS; b++)
                begin
                    word = random_word();
                    word[TLEN_LSB +: TLEN_W] = 7'd64;
                    send_item(ACT_TAIL, word, 0);
                end
            end

            // Drop valid and let the output side drain completely before going on
            if (k == 170)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (window_shadow.expected_bytes.size() != 0)
                    @(posedge clk);
            end

            word = random_word();
            pick = $urandom_range(99);
            if (pick < 45)
                act = ACT_WRITE;
            else if (pick < 65)
                act = ACT_COPY;
            else if (pick < 85)
                act = ACT_TAIL;
            else
                act = ACT_INDEX;

            if ($urandom_range(7) != 0)
                word[DIST_LSB +: DIST_W] = DIST_W'($urandom_range(64, 1));
            if ($urandom_range(9) != 0)
                word[CLEN_LSB +: CLEN_W] = CLEN_W'($urandom_range(16));
            if ($urandom_range(7) != 0)
                word[TLEN_LSB +: TLEN_W] = TLEN_W'($urandom_range(12, 1));
            if ($urandom_range(7) != 0)
                word[TOFS_LSB +: TOFS_W] = TOFS_W'($urandom_range(31));
            // Aim index reads at recently written bytes half the time
            if ($urandom_range(1) == 0)
                word[INDEX_LSB +: ADDR_W] =
                    addr_t'(int'(window_shadow.wr_ptr) - int'($urandom_range(64, 1)));

            send_item(act, word, tx_gap());
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Wait for the last predicted byte, then a little more for strays
        while (window_shadow.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        window_shadow.check_drained();

        $display("Run covered %0d input transactions (write, copy, tail, index) over %0d cycles,",
                 sent_count, cycle_count);
        $display("with %0d output bytes checked and %0d mismatches.",
                 window_shadow.matched, window_shadow.errors);
        if (window_shadow.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
design/lzhw_pkg.sv
design/lzhw_mem.sv
design/lzhw_seq.sv
design/lz_history_window_unit.sv
design/lzhw_checker.sv
tb/testbench.sv
